// ===== rtl/i2c_master_byte_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Concurrent assertion helpers that the engine's RTL uses. With SYNTH
// defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked at every rising edge of clk outside reset.
`define I2CMBE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2cmbe assertion failed");
// Checked at every rising edge of clk, reset included.
`define I2CMBE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("i2cmbe assertion failed");
`else
`define I2CMBE_ASSERT(lbl, prop)
`define I2CMBE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Operation codes, register map and field widths shared by the engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  // Operation / command codes.
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // Sub-step codes within a command.
  localparam logic [1:0] SUB_0 = 2'd0;
  localparam logic [1:0] SUB_1 = 2'd1;
  localparam logic [1:0] SUB_2 = 2'd2;

  // Bits per byte before the ACK slot.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] LAST_DATA_BIT = 4'd7;

  // Register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } result_t;

endpackage

// ===== rtl/i2c_master_byte_engine_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine
// Byte-level I2C master: start, write byte, read byte and stop sequencing.
// ----------------------------------------------------------------------------
// Usage. Every transfer on the in_ channel is one tick of the bus timing
// engine. in_tuser carries the command, in_tdata the write byte, the ACK
// choice for reads and the sampled SDA level. Every accepted tick produces
// exactly one result transfer on the out_ channel with the SCL and SDA
// drive levels, busy and done flags, the last byte read and the ACK seen.
// A command that arrives while the engine is busy is ignored.
// Each result is registered in the output register, or the skid register
// while the output stalls. Throughput is one tick per cycle while in_tready
// is high; the whole tick update is a single short combinational pass from
// the state registers into the result register. Bus phase length is set
// by the APB register phase_ticks (ticks per SCL phase, zero acts as one).
// When the receiver stalls, an output register and a skid register hold up
// to two results; in_tready drops only while the skid register is full and
// returns once the output drains. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) returns the engine to idle with SCL and
// SDA released, phase_ticks at 2 and both result registers empty.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input ticks.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] ack_after_read,
                                  // [9] sda_sample, [15:10] zero
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] scl_level, [1] sda_level,
                                  // [2] busy_res, [3] done_res,
                                  // [11:4] read_byte, [12] ack_seen,
                                  // [15:13] zero
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "i2c_master_byte_engine_unit_assert.svh"

  // --------------------------------------------------------------------------
  // Configuration register. Only the word address bit selects; byte offsets
  // within the word are ignored.
  // --------------------------------------------------------------------------
  logic [7:0] phase_ticks_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cmbe_pkg::PHASE_TICKS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == i2cmbe_pkg::REG_PHASE_TICKS)) begin
      phase_ticks_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == i2cmbe_pkg::REG_PHASE_TICKS) ?
                      {24'd0, phase_ticks_r} : 32'd0;

  // --------------------------------------------------------------------------
  // Engine state.
  // --------------------------------------------------------------------------
  logic [2:0] op_r,    op_nxt;
  logic [1:0] sub_r,   sub_nxt;
  logic [7:0] pc_r,    pc_nxt;
  logic [3:0] bc_r,    bc_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r,   scl_nxt;
  logic       sda_r,   sda_nxt;
  logic       ack_r,   ack_nxt;
  logic [7:0] last_read_r, last_read_nxt;
  logic       send_ack_r,  send_ack_nxt;
  logic       done_nxt;

  logic [2:0] cmd;
  logic [7:0] wdata;
  logic       ackr;
  logic       sda_in;
  logic [7:0] limit;
  logic [7:0] pc_inc;
  logic       in_acc;

  assign cmd    = in_tuser;
  assign wdata  = in_tdata[7:0];
  assign ackr   = in_tdata[8];
  assign sda_in = in_tdata[9];
  assign limit  = (phase_ticks_r == 8'd0) ? 8'd1 : phase_ticks_r;
  assign pc_inc = pc_r + 8'd1;

  // One tick of the engine. Intermediate values stay local to the block.
  always_comb begin
    logic [7:0] sh_new;
    logic [3:0] bc_new;
    op_nxt        = op_r;
    sub_nxt       = sub_r;
    pc_nxt        = pc_r;
    bc_nxt        = bc_r;
    shift_nxt     = shift_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    ack_nxt       = ack_r;
    last_read_nxt = last_read_r;
    send_ack_nxt  = send_ack_r;
    done_nxt      = 1'b0;
    sh_new        = {shift_r[6:0], 1'b0};
    bc_new        = bc_r + 4'd1;

    if (op_r == i2cmbe_pkg::OP_IDLE) begin
      // Accept a new command; its first phase starts on this tick.
      unique case (cmd)
        i2cmbe_pkg::OP_START: begin
          op_nxt  = cmd;
          sub_nxt = i2cmbe_pkg::SUB_0;
          pc_nxt  = 8'd0;
          bc_nxt  = 4'd0;
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
        end
        i2cmbe_pkg::OP_WRITE: begin
          op_nxt    = cmd;
          sub_nxt   = i2cmbe_pkg::SUB_0;
          pc_nxt    = 8'd0;
          bc_nxt    = 4'd0;
          shift_nxt = wdata;
          scl_nxt   = 1'b0;
          sda_nxt   = wdata[7];
        end
        i2cmbe_pkg::OP_READ: begin
          op_nxt       = cmd;
          sub_nxt      = i2cmbe_pkg::SUB_0;
          pc_nxt       = 8'd0;
          bc_nxt       = 4'd0;
          shift_nxt    = 8'd0;
          send_ack_nxt = ackr;
          scl_nxt      = 1'b0;
          sda_nxt      = 1'b1;
        end
        i2cmbe_pkg::OP_STOP: begin
          op_nxt  = cmd;
          sub_nxt = i2cmbe_pkg::SUB_0;
          pc_nxt  = 8'd0;
          bc_nxt  = 4'd0;
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        default: begin
          // No command, or an unused code: stay idle.
        end
      endcase
    end else if (pc_inc < limit) begin
      pc_nxt = pc_inc;
    end else begin
      // End of the current bus phase.
      pc_nxt = 8'd0;
      if ((op_r == i2cmbe_pkg::OP_START) || (op_r == i2cmbe_pkg::OP_STOP)) begin
        if (sub_r >= i2cmbe_pkg::SUB_2) begin
          op_nxt   = i2cmbe_pkg::OP_IDLE;
          sub_nxt  = i2cmbe_pkg::SUB_0;
          done_nxt = 1'b1;
        end else begin
          sub_nxt = sub_r + 2'd1;
          if (op_r == i2cmbe_pkg::OP_START) begin
            // Start: pull SDA low under high SCL, then pull SCL low.
            if (sub_r == i2cmbe_pkg::SUB_0) sda_nxt = 1'b0;
            else                            scl_nxt = 1'b0;
          end else begin
            // Stop: raise SCL first, then release SDA.
            if (sub_r == i2cmbe_pkg::SUB_0) scl_nxt = 1'b1;
            else                            sda_nxt = 1'b1;
          end
        end
      end else if (sub_r == i2cmbe_pkg::SUB_0) begin
        // Low phase over: raise SCL.
        sub_nxt = i2cmbe_pkg::SUB_1;
        scl_nxt = 1'b1;
      end else if (bc_r >= i2cmbe_pkg::BITS_PER_BYTE) begin
        // End of the ninth clock: sample the slave's ACK on writes.
        if (op_r == i2cmbe_pkg::OP_WRITE) ack_nxt = ~sda_in;
        scl_nxt  = 1'b0;
        sda_nxt  = 1'b1;
        op_nxt   = i2cmbe_pkg::OP_IDLE;
        sub_nxt  = i2cmbe_pkg::SUB_0;
        done_nxt = 1'b1;
      end else begin
        // End of a data bit's high phase: shift and start the next low phase.
        if (op_r == i2cmbe_pkg::OP_READ) begin
          sh_new = {shift_r[6:0], sda_in};
          if (bc_r == i2cmbe_pkg::LAST_DATA_BIT) last_read_nxt = sh_new;
        end
        shift_nxt = sh_new;
        bc_nxt    = bc_new;
        sub_nxt   = i2cmbe_pkg::SUB_0;
        scl_nxt   = 1'b0;
        if (op_r == i2cmbe_pkg::OP_WRITE) begin
          sda_nxt = (bc_new < i2cmbe_pkg::BITS_PER_BYTE) ? sh_new[7] : 1'b1;
        end else begin
          sda_nxt = (bc_new < i2cmbe_pkg::BITS_PER_BYTE) ? 1'b1 : ~send_ack_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= i2cmbe_pkg::OP_IDLE;
      sub_r       <= i2cmbe_pkg::SUB_0;
      pc_r        <= 8'd0;
      bc_r        <= 4'd0;
      shift_r     <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      last_read_r <= 8'd0;
      send_ack_r  <= 1'b0;
    end else if (in_acc) begin
      op_r        <= op_nxt;
      sub_r       <= sub_nxt;
      pc_r        <= pc_nxt;
      bc_r        <= bc_nxt;
      shift_r     <= shift_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      ack_r       <= ack_nxt;
      last_read_r <= last_read_nxt;
      send_ack_r  <= send_ack_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register with a skid register behind it.
  // --------------------------------------------------------------------------
  i2cmbe_pkg::result_t res;
  i2cmbe_pkg::result_t out_data_r, skid_data_r;
  logic out_valid_r, skid_valid_r;
  logic out_take;

  assign res.scl_level = scl_nxt;
  assign res.sda_level = sda_nxt;
  assign res.busy_res  = (op_nxt != i2cmbe_pkg::OP_IDLE);
  assign res.done_res  = done_nxt;
  assign res.read_byte = last_read_nxt;
  assign res.ack_seen  = ack_nxt;

  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign out_take  = out_valid_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (in_acc && out_valid_r && !out_take) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r.ack_seen, out_data_r.read_byte,
                       out_data_r.done_res, out_data_r.busy_res,
                       out_data_r.sda_level, out_data_r.scl_level};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `I2CMBE_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  `I2CMBE_ASSERT(a_idle_clean, (op_r == i2cmbe_pkg::OP_IDLE) |-> ((sub_r == i2cmbe_pkg::SUB_0) && (pc_r == 8'd0)))
  `I2CMBE_ASSERT(a_bit_count_range, bc_r <= i2cmbe_pkg::BITS_PER_BYTE)
  `I2CMBE_ASSERT(a_byte_sub_range,
                 ((op_r == i2cmbe_pkg::OP_WRITE) || (op_r == i2cmbe_pkg::OP_READ))
                 |-> (sub_r <= i2cmbe_pkg::SUB_1))
  `I2CMBE_ASSERT(a_stall_keeps_two,
                 (out_valid_r && !out_tready && in_acc) |=> (out_valid_r && skid_valid_r))

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives bus ticks into the engine on the in_ stream, predicts the SCL/SDA
// levels and status of every tick with a cycle-true model of the sequencer,
// and compares every result transfer on the out_ stream field by field.
// Covers start, write, read and stop at several phase lengths, commands
// that arrive while busy, unused command codes, random stalls on both
// sides and a long receiver hold-off that backs the engine up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Highest command code the 3-bit field can carry; codes above OP_STOP
  // are unused and must behave like no command.
  localparam logic [2:0]  CMD_MAX          = 3'd7;
  localparam logic [7:0]  PHASE_TICKS_MAX  = 8'd255;
  localparam int unsigned ADDR_W           = i2cmbe_pkg::CFG_ADDR_W;
  localparam logic [ADDR_W-1:0] PHASE_TICKS_ADDR =
    ADDR_W'(4 * i2cmbe_pkg::REG_PHASE_TICKS);
  localparam int unsigned MAX_GAP          = 19;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned RUN_LIMIT        = 800000;
  localparam int unsigned RANDOM_CHUNK     = 135;
  localparam int unsigned HOLD_OFF_CYCLES  = 250;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Block ports, all driven to known values from time zero.
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata    = '0;
  logic [2:0]        in_tuser    = i2cmbe_pkg::OP_IDLE;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [15:0]       out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  i2c_master_byte_engine_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Shared bookkeeping.
  // --------------------------------------------------------------------------
  i2cmbe_pkg::result_t pending_bus_states[$];  // predicted result of every accepted tick
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned ticks_sent   = 0;
  bit          tx_idle_on   = 1'b1;    // sender draws random gaps
  bit          rx_idle_on   = 1'b1;    // receiver draws random stalls
  int unsigned rx_hold_req  = 0;       // one long receiver hold-off, in cycles

  // --------------------------------------------------------------------------
  // Bus sequencer model. It mirrors the engine's state and is advanced once
  // for every accepted tick, in acceptance order.
  // --------------------------------------------------------------------------
  logic [7:0] cfg_phase_ticks = i2cmbe_pkg::PHASE_TICKS_RESET;
  logic [2:0] eng_op        = i2cmbe_pkg::OP_IDLE;
  logic [1:0] eng_sub       = i2cmbe_pkg::SUB_0;
  logic [7:0] eng_cnt       = '0;
  logic [3:0] eng_bit       = '0;
  logic [7:0] eng_shift     = '0;
  logic       eng_scl       = 1'b1;
  logic       eng_sda       = 1'b1;
  logic       eng_ack       = 1'b0;
  logic [7:0] eng_last_read = '0;
  logic       eng_send_ack  = 1'b0;
  logic       eng_done      = 1'b0;

  // Drive levels on entry to the current phase.
  function automatic void enter_bus_phase();
    case (eng_op)
      i2cmbe_pkg::OP_START: begin
        if (eng_sub == i2cmbe_pkg::SUB_0) begin
          eng_sda = 1'b1;
          eng_scl = 1'b1;
        end else if (eng_sub == i2cmbe_pkg::SUB_1) begin
          eng_sda = 1'b0;
        end else begin
          eng_scl = 1'b0;
        end
      end
      i2cmbe_pkg::OP_STOP: begin
        // SCL rises before SDA so that the slave sees a proper stop.
        if (eng_sub == i2cmbe_pkg::SUB_0) begin
          eng_scl = 1'b0;
          eng_sda = 1'b0;
        end else if (eng_sub == i2cmbe_pkg::SUB_1) begin
          eng_scl = 1'b1;
        end else begin
          eng_sda = 1'b1;
        end
      end
      default: begin
        if (eng_sub == i2cmbe_pkg::SUB_0) begin
          eng_scl = 1'b0;
          if (eng_op == i2cmbe_pkg::OP_WRITE)
            eng_sda = (eng_bit < i2cmbe_pkg::BITS_PER_BYTE) ? eng_shift[7] : 1'b1;
          else
            eng_sda = (eng_bit < i2cmbe_pkg::BITS_PER_BYTE) ? 1'b1 : ~eng_send_ack;
        end else begin
          eng_scl = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic void finish_command();
    eng_op   = i2cmbe_pkg::OP_IDLE;
    eng_sub  = i2cmbe_pkg::SUB_0;
    eng_cnt  = '0;
    eng_done = 1'b1;
  endfunction

  // End of a phase; sda_in is the level sampled on this tick.
  function automatic void leave_bus_phase(input logic sda_in);
    if (eng_op == i2cmbe_pkg::OP_START || eng_op == i2cmbe_pkg::OP_STOP) begin
      if (eng_sub >= i2cmbe_pkg::SUB_2) begin
        finish_command();
      end else begin
        eng_sub = eng_sub + 2'd1;
        enter_bus_phase();
      end
    end else if (eng_sub == i2cmbe_pkg::SUB_0) begin
      eng_sub = i2cmbe_pkg::SUB_1;
      enter_bus_phase();
    end else if (eng_bit >= i2cmbe_pkg::BITS_PER_BYTE) begin
      // Ninth clock: a write samples the slave's ACK (low means ACK).
      if (eng_op == i2cmbe_pkg::OP_WRITE)
        eng_ack = ~sda_in;
      eng_scl = 1'b0;
      eng_sda = 1'b1;
      finish_command();
    end else begin
      if (eng_op == i2cmbe_pkg::OP_WRITE) begin
        eng_shift = eng_shift << 1;
      end else begin
        eng_shift = {eng_shift[6:0], sda_in};
        if (eng_bit == i2cmbe_pkg::LAST_DATA_BIT)
          eng_last_read = eng_shift;
      end
      eng_bit = eng_bit + 4'd1;
      eng_sub = i2cmbe_pkg::SUB_0;
      enter_bus_phase();
    end
  endfunction

  // Advances the model by one tick and returns the levels after it.
  function automatic i2cmbe_pkg::result_t next_bus_state(input logic [2:0] cmd,
                                                         input logic [7:0] wd,
                                                         input logic ackr,
                                                         input logic sda_in);
    i2cmbe_pkg::result_t r;
    logic [7:0]          limit;
    limit    = (cfg_phase_ticks == 8'd0) ? 8'd1 : cfg_phase_ticks;
    eng_done = 1'b0;
    if (eng_op == i2cmbe_pkg::OP_IDLE) begin
      if (cmd >= i2cmbe_pkg::OP_START && cmd <= i2cmbe_pkg::OP_STOP) begin
        eng_op  = cmd;
        eng_sub = i2cmbe_pkg::SUB_0;
        eng_cnt = '0;
        eng_bit = '0;
        if (cmd == i2cmbe_pkg::OP_WRITE) begin
          eng_shift = wd;
        end else if (cmd == i2cmbe_pkg::OP_READ) begin
          eng_shift    = '0;
          eng_send_ack = ackr;
        end
        enter_bus_phase();
      end
    end else begin
      // Commands are ignored here, also on the tick that completes one.
      eng_cnt = eng_cnt + 8'd1;
      if (eng_cnt >= limit) begin
        eng_cnt = '0;
        leave_bus_phase(sda_in);
      end
    end
    r.scl_level = eng_scl;
    r.sda_level = eng_sda;
    r.busy_res  = (eng_op != i2cmbe_pkg::OP_IDLE);
    r.done_res  = eng_done;
    r.read_byte = eng_last_read;
    r.ack_seen  = eng_ack;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting: the first few are printed, the rest only counted.
  // --------------------------------------------------------------------------
  task automatic note_error(input string what);
    if (error_count < MAX_REPORTS)
      $display("ERROR cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker. Every result transfer is unpacked and compared with the
  // oldest predicted tick.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    i2cmbe_pkg::result_t got;
    i2cmbe_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl_level = out_tdata[0];
      got.sda_level = out_tdata[1];
      got.busy_res  = out_tdata[2];
      got.done_res  = out_tdata[3];
      got.read_byte = out_tdata[11:4];
      got.ack_seen  = out_tdata[12];
      if (pending_bus_states.size() == 0) begin
        note_error($sformatf("result transfer %h with no tick pending", out_tdata));
      end else begin
        want = pending_bus_states.pop_front();
        if (got.scl_level != want.scl_level || got.sda_level != want.sda_level ||
            got.busy_res != want.busy_res || got.done_res != want.done_res ||
            got.read_byte != want.read_byte || got.ack_seen != want.ack_seen)
          note_error($sformatf({"expected scl %b sda %b busy %b done %b byte %h ack %b, ",
                                "got scl %b sda %b busy %b done %b byte %h ack %b"},
                               want.scl_level, want.sda_level, want.busy_res,
                               want.done_res, want.read_byte, want.ack_seen,
                               got.scl_level, got.sda_level, got.busy_res,
                               got.done_res, got.read_byte, got.ack_seen));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. Before each result it stalls for a random number of
  // cycles; a pending hold-off request is added to that stall once, which
  // lets the engine fill both result registers and drop in_tready.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int unsigned stall;
    forever begin
      @(negedge clk);
      stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      stall += rx_hold_req;
      rx_hold_req = 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // Tick sender. Called at a falling edge; returns at the falling edge after
  // the transfer. tvalid stays high into the next call, which lowers it
  // only when it draws a gap.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] wd,
                           input logic ackr, input logic sda);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, sda, ackr, wd};
    do @(posedge clk); while (!in_tready);
    pending_bus_states.push_back(next_bus_state(cmd, wd, ackr, sda));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Issues one command on an idle engine and keeps ticking until it is idle
  // again. The slave side follows the bit being clocked: read data bits come
  // from slave_byte, the write ACK slot sees slave_ack. With noise set, every
  // busy tick also carries a random command, which must be ignored.
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] wd, input logic ackr,
                             input logic [7:0] slave_byte, input logic slave_ack,
                             input bit noise);
    logic       sda;
    logic [2:0] busy_cmd;
    send_tick(cmd, wd, ackr, 1'($urandom_range(0, 1)));
    while (eng_op != i2cmbe_pkg::OP_IDLE) begin
      if (eng_op == i2cmbe_pkg::OP_READ && eng_bit < i2cmbe_pkg::BITS_PER_BYTE)
        sda = slave_byte[3'(i2cmbe_pkg::LAST_DATA_BIT - eng_bit)];
      else if (eng_op == i2cmbe_pkg::OP_WRITE && eng_bit >= i2cmbe_pkg::BITS_PER_BYTE)
        sda = slave_ack;
      else
        sda = 1'($urandom_range(0, 1));
      busy_cmd = noise ? 3'($urandom_range(0, CMD_MAX)) : i2cmbe_pkg::OP_IDLE;
      send_tick(busy_cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
    end
  endtask

  // Lets any command finish, then stops sending until every predicted tick
  // has come back.
  task automatic bus_quiesce();
    while (eng_op != i2cmbe_pkg::OP_IDLE)
      send_tick(i2cmbe_pkg::OP_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_bus_states.size() != 0) @(negedge clk);
  endtask

  // APB write of phase_ticks followed by a read-back. Only called while the
  // stream is quiet.
  task automatic write_phase_ticks(input logic [7:0] value);
    logic [31:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PHASE_TICKS_ADDR;
    cfg_pwdata  <= {24'b0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_phase_ticks = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    if (readback != {24'b0, value})
      note_error($sformatf("phase_ticks read back %h, wrote %h", readback, value));
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset levels and the reset value of phase_ticks: idle ticks show both
  // lines released, then a start and a stop run with two ticks per phase.
  task automatic test_reset_defaults();
    repeat (3) send_tick(i2cmbe_pkg::OP_IDLE, 8'h00, 1'b0, 1'b1);
    run_command(i2cmbe_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    bus_quiesce();
  endtask

  // Every command with field extremes at the shortest phase: writes with
  // ACK and NACK from the slave, reads of all zeros and all ones with ACK
  // and NACK, unused command codes, and commands thrown at a busy engine,
  // including on the tick that completes a command.
  task automatic test_directed_commands();
    write_phase_ticks(8'd1);
    run_command(i2cmbe_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cmbe_pkg::OP_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0);
    run_command(i2cmbe_pkg::OP_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
    run_command(i2cmbe_pkg::OP_READ, 8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0);
    run_command(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, 8'h5A, 1'b0, 1'b0);
    run_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    for (int c = i2cmbe_pkg::OP_STOP + 1; c <= CMD_MAX; c++)
      send_tick(3'(c), 8'hFF, 1'b1, 1'b0);
    run_command(i2cmbe_pkg::OP_START, 8'h3C, 1'b1, 8'h00, 1'b0, 1'b1);
    run_command(i2cmbe_pkg::OP_WRITE, 8'hC3, 1'b0, 8'h00, 1'b0, 1'b1);
    run_command(i2cmbe_pkg::OP_READ, 8'h00, 1'b0, 8'h96, 1'b1, 1'b1);
    run_command(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    bus_quiesce();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back-to-back ticks; the engine must stall its input without losing or
  // repeating a result. The sender then waits for the stream to drain.
  task automatic test_output_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_req = HOLD_OFF_CYCLES;
    run_command(i2cmbe_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    run_command(i2cmbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 1'b0, 1'b0);
    bus_quiesce();
    tx_idle_on = 1'b1;
  endtask

  // Longest phase: a single start at 255 ticks per phase.
  task automatic test_longest_phase();
    write_phase_ticks(PHASE_TICKS_MAX);
    run_command(i2cmbe_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    bus_quiesce();
  endtask

  // One random transaction. Most are well formed (start, one to three
  // bytes, usually a stop) with random content; the rest are single stray
  // commands, unused codes or idle ticks.
  task automatic random_transaction();
    int unsigned n_bytes;
    bit          noise;
    noise = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 8) begin
      run_command(i2cmbe_pkg::OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'h00, 1'b0, noise);
      n_bytes = $urandom_range(1, 3);
      repeat (n_bytes) begin
        if ($urandom_range(0, 1) == 0)
          run_command(i2cmbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 8'h00, ($urandom_range(0, 3) == 0), noise);
        else
          run_command(i2cmbe_pkg::OP_READ, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), noise);
      end
      if ($urandom_range(0, 4) != 0)
        run_command(i2cmbe_pkg::OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    8'h00, 1'b0, noise);
    end else begin
      run_command(3'($urandom_range(0, CMD_MAX)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), noise);
    end
  endtask

  // Random traffic over several phase lengths, zero among them (acts as
  // one). Idling on each side is switched per transaction so that some
  // stretches run with no gaps at all.
  task automatic test_random_traffic();
    logic [7:0]  settings[5];
    int unsigned target;
    settings[0] = 8'd1;
    settings[1] = 8'd2;
    settings[2] = 8'd0;
    settings[3] = 8'd3;
    settings[4] = 8'($urandom_range(1, 6));
    for (int s = 0; s < 5; s++) begin
      bus_quiesce();
      write_phase_ticks(settings[s]);
      target = ticks_sent + RANDOM_CHUNK;
      while (ticks_sent < target) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        random_transaction();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    bus_quiesce();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_directed_commands();
    test_output_backpressure();
    test_random_traffic();
    test_longest_phase();

    // The stream is drained; keep running so that the result pipeline can
    // show any stray transfer.
    repeat (4) @(negedge clk);
    if (pending_bus_states.size() != 0)
      note_error($sformatf("%0d ticks never produced a result", pending_bus_states.size()));
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
